[src/bbpa_pkg.sv]
// Package for the bitmap block pool allocator.
// Holds command and status codes and size constants; no dependencies.
`default_nettype none
package bbpa_pkg;
    localparam int NUM_GROUPS_DEF   = 16;
    localparam int GROUP_BLOCKS_DEF = 32;
    localparam int LEVEL_W          = 12;
    localparam int CNT_W            = 10;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 12'sd2047;

    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_FREE    = 3'd1;
    localparam logic [2:0] CMD_RES_ONE = 3'd2;
    localparam logic [2:0] CMD_RES_PERM = 3'd3;
    localparam logic [2:0] CMD_RELEASE = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_FOREIGN  = 2'd2;
    localparam logic [1:0] ST_DOUBLE   = 2'd3;

    localparam logic [1:0] RS_NONE = 2'd0;
    localparam logic [1:0] RS_ONE  = 2'd1;
    localparam logic [1:0] RS_PERM = 2'd2;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,       // latch command fields, set scan index to top or bottom
        OP_SCAN_DOWN,  // inspect group at index, step down
        OP_FIND_LOW,   // inspect for lowest inactive, step up
        OP_ACTIVATE,   // activate group at index
        OP_TAKE,       // take lowest free bit of group at index
        OP_FREE,       // check and clear a bit
        OP_RETIRE,     // inspect/retire group at index, step up
        OP_RES_FIN,    // update reserve level
        OP_REL_FIN     // negate level if permanent
    } t_op;

    typedef struct packed {
        t_op  op;
        logic from_top;  // scan index start at top
    } t_ctl;

    typedef struct packed {
        logic idx_last;     // index at end of scan range
        logic hit;          // inspected group qualifies
        logic have_enough;  // free blocks cover amount
        logic in_pool;      // block to free lies in an active group
        logic free_ok;      // free passed its checks
        logic retire_ok;    // retire conditions hold after free
        logic level_none;   // level equals group size
    } t_sts;
endpackage
`default_nettype wire

[src/bbpa_datapath.sv]
// Datapath for the bitmap block pool allocator: group bitmaps, counters, level.
// Depends on bbpa_pkg.
`default_nettype none
module bbpa_datapath
    import bbpa_pkg::*;
#(
    parameter int NUM_GROUPS   = NUM_GROUPS_DEF,
    parameter int GROUP_BLOCKS = GROUP_BLOCKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ctl        i_ctl,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [8:0]  i_block_number,
    input  wire logic [9:0]  i_amount,
    output t_sts             o_sts,
    output logic [8:0]       o_block_res,
    output logic [CNT_W-1:0] o_have,
    output logic [CNT_W-1:0] o_used,
    output logic [CNT_W-1:0] o_cap,
    output logic [1:0]       o_rstate
);
    localparam int GI_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int BI_W = $clog2(GROUP_BLOCKS);
    localparam logic [GROUP_BLOCKS-1:0] FULL = '1;
    localparam logic [CNT_W-1:0] GB = CNT_W'(GROUP_BLOCKS);

    logic [GROUP_BLOCKS-1:0] r_bitmap [NUM_GROUPS];
    logic [NUM_GROUPS-1:0]   r_active;
    logic [CNT_W-1:0]        r_used, r_cap, r_have, r_amount;
    logic signed [LEVEL_W-1:0] r_level;
    logic [GI_W-1:0]         r_idx;
    logic [8:0]              r_bn, r_block_res;

    logic [GROUP_BLOCKS-1:0] w_row;
    logic                    w_act;
    logic [BI_W-1:0]         w_low;
    logic [8:0]              w_grp_full;
    logic [GI_W-1:0]         w_fgrp;
    logic [BI_W-1:0]         w_fbit;
    logic                    w_in_range;
    logic signed [LEVEL_W+1:0] w_sum;
    logic signed [LEVEL_W-1:0] w_clamp;
    logic [GI_W-1:0]         w_last;

    assign w_row = r_bitmap[r_idx];
    assign w_act = r_active[r_idx];
    assign w_grp_full = 9'(r_bn / GROUP_BLOCKS);
    assign w_fgrp = w_grp_full[GI_W-1:0];
    assign w_fbit = BI_W'(r_bn % GROUP_BLOCKS);
    assign w_in_range = (w_grp_full < 9'(NUM_GROUPS)) && r_active[w_fgrp];
    assign w_last = i_ctl.from_top ? GI_W'(0) : GI_W'(NUM_GROUPS - 1);

    always_comb begin
        w_low = BI_W'(GROUP_BLOCKS - 1);
        for (int b = GROUP_BLOCKS - 2; b >= 0; b--) begin
            if (!w_row[b]) w_low = BI_W'(b);
        end
    end

    always_comb begin
        w_sum = (LEVEL_W+2)'(r_level) + (LEVEL_W+2)'($signed({1'b0, r_have}));
        if (w_sum > (LEVEL_W+2)'(LEVEL_MAX)) w_clamp = LEVEL_MAX;
        else if (w_sum < -(LEVEL_W+2)'(LEVEL_MAX)) w_clamp = -LEVEL_MAX;
        else w_clamp = LEVEL_W'(w_sum);
    end

    always_comb begin
        o_sts.idx_last    = (r_idx == w_last);
        unique case (i_ctl.op)
            OP_SCAN_DOWN: o_sts.hit = w_act && (w_row != FULL);
            OP_FIND_LOW:  o_sts.hit = !w_act;
            OP_RETIRE:    o_sts.hit = w_act && (w_row == '0) && (r_idx != '0);
            default:      o_sts.hit = 1'b0;
        endcase
        o_sts.have_enough = (r_have >= r_amount);
        o_sts.in_pool     = w_in_range;
        o_sts.free_ok     = w_in_range && r_bitmap[w_fgrp][w_fbit];
        o_sts.retire_ok   = ($countones(r_active) > 1) && (r_level == LEVEL_W'(GROUP_BLOCKS))
                            && ({1'b0, r_cap} > {r_used, 1'b0});
        o_sts.level_none  = (r_level == LEVEL_W'(GROUP_BLOCKS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_GROUPS; g++) r_bitmap[g] <= '0;
            r_active    <= NUM_GROUPS'(1);
            r_used      <= '0;
            r_cap       <= GB;
            r_level     <= LEVEL_W'(GROUP_BLOCKS);
            r_idx       <= '0;
            r_have      <= '0;
            r_amount    <= '0;
            r_bn        <= '0;
            r_block_res <= '0;
        end else begin
            unique case (i_ctl.op)
                OP_LOAD: begin
                    r_bn        <= i_block_number;
                    r_amount    <= i_amount;
                    r_have      <= r_cap - r_used;
                    r_block_res <= '0;
                    r_idx       <= i_ctl.from_top ? GI_W'(NUM_GROUPS - 1) : '0;
                end
                OP_SCAN_DOWN: if (!o_sts.hit && !o_sts.idx_last) r_idx <= r_idx - 1'b1;
                OP_FIND_LOW:  if (!o_sts.hit && !o_sts.idx_last) r_idx <= r_idx + 1'b1;
                OP_ACTIVATE: begin
                    r_active[r_idx] <= 1'b1;
                    r_bitmap[r_idx] <= '0;
                    r_cap           <= r_cap + GB;
                    r_have          <= r_have + GB;
                end
                OP_TAKE: begin
                    r_bitmap[r_idx][w_low] <= 1'b1;
                    r_used      <= r_used + 1'b1;
                    if (r_level > 0) r_level <= r_level - 1'b1;
                    r_block_res <= 9'(r_idx * GROUP_BLOCKS) + 9'(w_low);
                end
                OP_FREE: begin
                    r_bitmap[w_fgrp][w_fbit] <= 1'b0;
                    r_used <= r_used - 1'b1;
                    r_idx  <= '0;
                end
                OP_RETIRE: begin
                    if (o_sts.hit) begin
                        r_active[r_idx] <= 1'b0;
                        r_bitmap[r_idx] <= '0;
                        r_cap           <= r_cap - GB;
                    end
                    if (!o_sts.idx_last) r_idx <= r_idx + 1'b1;
                end
                OP_RES_FIN: r_level <= (i_cmd == CMD_RES_PERM) ? -w_clamp : w_clamp;
                OP_REL_FIN: if (r_level < 0) r_level <= -r_level;
                default: ;
            endcase
        end
    end

    assign o_block_res = r_block_res;
    assign o_have      = r_have;
    assign o_used      = r_used;
    assign o_cap       = r_cap;
    always_comb begin
        if (r_level == LEVEL_W'(GROUP_BLOCKS)) o_rstate = RS_NONE;
        else if (r_level < 0)                  o_rstate = RS_PERM;
        else                                   o_rstate = RS_ONE;
    end
endmodule
`default_nettype wire

[src/bbpa_ctrl.sv]
// Controller state machine for the bitmap block pool allocator.
// Depends on bbpa_pkg; drives bbpa_datapath through t_ctl.
`default_nettype none
module bbpa_ctrl
    import bbpa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [2:0] i_cmd,
    input  wire t_sts       i_sts,
    output t_ctl            o_ctl,
    output logic [2:0]      o_cmd,
    output logic            o_busy,
    output logic            o_done,
    output logic [1:0]      o_status,
    output logic            o_res_valid
);
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_FIND, S_ACT, S_TAKE, S_FREE, S_RET_ONE,
        S_RES_CHK, S_RES_FIN, S_REL, S_RET_ALL, S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cmd;
    logic [1:0] r_status, n_status;
    logic       r_done, r_resv;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_ctl.op = OP_NONE;
        o_ctl.from_top = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                o_ctl.op = OP_LOAD;
                o_ctl.from_top = (i_cmd == CMD_ALLOC);
                n_status = ST_OK;
                priority case (i_cmd)
                    CMD_ALLOC:   n_state = S_SCAN;
                    CMD_FREE:    n_state = S_FREE;
                    CMD_RES_ONE, CMD_RES_PERM: n_state = S_RES_CHK;
                    CMD_RELEASE: n_state = S_REL;
                    default:     n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                o_ctl.op = OP_SCAN_DOWN;
                o_ctl.from_top = 1'b1;
                if (i_sts.hit) n_state = S_TAKE;
                else if (i_sts.idx_last) n_state = S_FIND;
            end
            S_FIND: begin
                o_ctl.op = OP_FIND_LOW;
                if (i_sts.hit) n_state = S_ACT;
                else if (i_sts.idx_last) begin
                    n_status = ST_NO_SPACE;
                    n_state  = (r_cmd == CMD_ALLOC) ? S_DONE : S_RES_FIN;
                end
            end
            S_ACT: begin
                o_ctl.op = OP_ACTIVATE;
                n_state  = (r_cmd == CMD_ALLOC) ? S_TAKE : S_RES_CHK;
            end
            S_TAKE: begin
                o_ctl.op = OP_TAKE;
                n_state  = S_DONE;
            end
            S_FREE: begin
                if (!i_sts.free_ok) begin
                    n_status = (i_sts.in_pool) ? ST_DOUBLE : ST_FOREIGN;
                    n_state  = S_DONE;
                end else begin
                    o_ctl.op = OP_FREE;
                    n_state  = S_RET_ONE;
                end
            end
            S_RET_ONE: begin
                if (!i_sts.retire_ok) n_state = S_DONE;
                else begin
                    o_ctl.op = OP_RETIRE;
                    if (i_sts.hit || i_sts.idx_last) n_state = S_DONE;
                end
            end
            S_RES_CHK: n_state = i_sts.have_enough ? S_RES_FIN : S_FIND;
            S_RES_FIN: begin
                o_ctl.op = OP_RES_FIN;
                n_state  = S_DONE;
            end
            S_REL: begin
                o_ctl.op = OP_REL_FIN;
                n_state  = S_RET_ALL;
            end
            S_RET_ALL: begin
                if (!i_sts.level_none) n_state = S_DONE;
                else begin
                    o_ctl.op = OP_RETIRE;
                    if (i_sts.idx_last) n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmd    <= CMD_ALLOC;
            r_status <= ST_OK;
            r_done   <= 1'b0;
            r_resv   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_done   <= (r_state == S_DONE);
            if (r_state == S_IDLE && i_start) begin
                r_cmd  <= i_cmd;
                r_resv <= (i_cmd == CMD_RES_ONE) || (i_cmd == CMD_RES_PERM);
            end
        end
    end

    assign o_cmd       = r_cmd;
    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_res_valid = r_resv;
endmodule
`default_nettype wire

[src/bitmap_block_pool_allocator_unit.sv]
// Bitmap block pool allocator, top level: controller plus datapath.
// Each command steps through the controller states from accept to the o_done strobe; alloc,
// free, reserve and release may scan the groups, an unknown command goes straight to done.
// One command at a time: a new one is taken only when idle; busy drops in the strobe cycle.
// Reset (synchronous, active low) leaves slot 0 active, pool empty, unreserved.
// Results show for one cycle on o_done; the receiver cannot stall.
`default_nettype none
module bitmap_block_pool_allocator_unit
    import bbpa_pkg::*;
#(
    parameter int NUM_GROUPS   = NUM_GROUPS_DEF,
    parameter int GROUP_BLOCKS = GROUP_BLOCKS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_cmd,
    input  wire logic [8:0] i_block_number,
    input  wire logic [9:0] i_amount,
    output logic            o_done,
    output logic [1:0]      o_status,
    output logic [8:0]      o_block_number_res,
    output logic [9:0]      o_reserved_count,
    output logic [9:0]      o_used_count,
    output logic [9:0]      o_capacity_count,
    output logic [1:0]      o_reservation_state
);
    t_ctl       w_ctl;
    t_sts       w_sts;
    logic [2:0] w_cmd;
    logic [9:0] w_have;
    logic       w_resv;
    logic [1:0] w_status;

    bbpa_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_cmd,
        .i_sts(w_sts), .o_ctl(w_ctl), .o_cmd(w_cmd), .o_busy(busy),
        .o_done, .o_status(w_status), .o_res_valid(w_resv)
    );

    bbpa_datapath #(.NUM_GROUPS(NUM_GROUPS), .GROUP_BLOCKS(GROUP_BLOCKS)) u_dp (
        .i_clk, .i_rst_n, .i_ctl(w_ctl), .i_cmd(w_cmd),
        .i_block_number, .i_amount,
        .o_sts(w_sts), .o_block_res(o_block_number_res), .o_have(w_have),
        .o_used(o_used_count), .o_cap(o_capacity_count),
        .o_rstate(o_reservation_state)
    );

    assign o_status         = w_status;
    assign o_reserved_count = w_resv ? w_have : '0;
endmodule
`default_nettype wire

[src/bbpa_checker.sv]
// Port-level checker for the bitmap block pool allocator.
// Depends on bbpa_pkg; bound to the top level.
`default_nettype none
module bbpa_checker
    import bbpa_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic [9:0] o_used_count,
    input wire logic [9:0] o_capacity_count
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("no busy after accept");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("strobe while busy");
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_used_count <= o_capacity_count) else $error("used over capacity");
    a_cap_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_capacity_count >= 10'(GROUP_BLOCKS_DEF)) else $error("capacity low");
endmodule

bind bitmap_block_pool_allocator_unit bbpa_checker u_bbpa_checker (
    .i_clk, .i_rst_n, .start, .busy, .o_done,
    .o_used_count, .o_capacity_count
);
`default_nettype wire
